/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, quiet during reset.
`define PM16_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define PM16_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/pm16_pkg.sv */
package pm16_pkg;

	localparam int DEF_MAX_CHANNELS    = 8;
	localparam int DEF_MAX_SAMPLE_BITS = 32;

	// register widths
	localparam int BITS_W     = 6;
	localparam int CHANS_W    = 4;
	localparam int PAD_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam int BYTE_W      = 8;
	localparam int OUT_W       = 16;
	localparam int SH_W        = 5;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [BITS_W-1:0]  BITS_RST  = 6'd16;
	localparam logic [CHANS_W-1:0] CHANS_RST = 4'd1;
	localparam logic [PAD_W-1:0]   PAD_RST   = 3'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BITS  = 2'd0,
		REG_CHANS = 2'd1,
		REG_PAD   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [BITS_W-1:0]  bits;
		logic [CHANS_W-1:0] chans;
		logic [PAD_W-1:0]   pad;
	} cfg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} bk_state_t;

endpackage

/* src/pcm_frame_to_mono16.sv */
// PCM frame to mono mixer.
// Input channel: one raw byte of a PCM data chunk per transfer; a byte is
// taken at a rising edge with push high and full low. Result channel: the
// oldest mixed sample sits on mono_sample while empty is low and is taken at
// a rising edge with pop high.
// Configuration: cfg_we writes cfg_data into the register picked by
// cfg_index (sample width, channel count, pad bytes) in the same cycle; any
// write to a listed register also restarts frame assembly. Write only while
// the block holds no unfinished frame.
// Throughput: the byte front takes one byte per cycle while full is low. Each
// finished frame then passes a two-entry queue to the mixing back end, whose
// divide length is set by the channel limit (eight by default), whatever the
// channel count: it scales the sum, runs a bit-serial divide and hands the
// result over before it takes the next frame, so short frames are paced by the
// divider. Reset clears the frame state, the frame queue, the back end and the
// output register, and sets the registers to 16 bits, one channel, no padding.
// A stalled receiver first fills the output register, then the back end, then
// the queue, after which full rises and input waits.
`include "assert_macros.svh"

module pcm_frame_to_mono16 #(
	parameter int MAX_CHANNELS    = pm16_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_SAMPLE_BITS = pm16_pkg::DEF_MAX_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pm16_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pm16_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                push,
	output logic                                full,
	input  logic [pm16_pkg::BYTE_W-1:0]         data_byte,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [pm16_pkg::OUT_W-1:0]   mono_sample
);

	localparam int SUM_W = MAX_SAMPLE_BITS + $clog2(MAX_CHANNELS);
	localparam int BW    = $clog2(MAX_SAMPLE_BITS + 1);
	localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int ENT_W = SUM_W + BW + CH_W;

	// configuration registers
	pm16_pkg::cfg_t cfg_q;
	logic           cfg_clear;

	// front to queue
	logic                    in_accept;
	logic                    q_push;
	logic signed [SUM_W-1:0] f_sum;
	logic [BW-1:0]           f_bits;
	logic [CH_W-1:0]         f_chans;
	logic [ENT_W-1:0]        q_din;

	// queue to back
	logic                    q_full;
	logic                    q_empty;
	logic                    q_pop;
	logic [ENT_W-1:0]        q_dout;

	// back to output register
	logic                              res_valid;
	logic                              res_ready;
	logic signed [pm16_pkg::OUT_W-1:0] res_data;
	logic                              out_valid_q;
	logic signed [pm16_pkg::OUT_W-1:0] out_data_q;

	// decode register writes; an unlisted index is dropped
	always_comb begin
		unique case (cfg_index) inside
			pm16_pkg::REG_BITS,
			pm16_pkg::REG_CHANS,
			pm16_pkg::REG_PAD: cfg_clear = cfg_we;
			default:           cfg_clear = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bits  <= pm16_pkg::BITS_RST;
			cfg_q.chans <= pm16_pkg::CHANS_RST;
			cfg_q.pad   <= pm16_pkg::PAD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pm16_pkg::REG_BITS:  cfg_q.bits  <= pm16_pkg::BITS_W'(cfg_data);
				pm16_pkg::REG_CHANS: cfg_q.chans <= pm16_pkg::CHANS_W'(cfg_data);
				pm16_pkg::REG_PAD:   cfg_q.pad   <= pm16_pkg::PAD_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// take a byte only while the frame queue has room
	assign full      = q_full;
	assign in_accept = push && !q_full;

	pm16_front #(
		.MAX_CHANNELS    (MAX_CHANNELS),
		.MAX_SAMPLE_BITS (MAX_SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clear    (cfg_clear),
		.in_valid (in_accept),
		.in_byte  (data_byte),
		.q_push   (q_push),
		.q_sum    (f_sum),
		.q_bits   (f_bits),
		.q_chans  (f_chans)
	);

	assign q_din = {f_sum, f_bits, f_chans};

	pm16_fifo #(
		.W     (ENT_W),
		.DEPTH (pm16_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	pm16_back #(
		.MAX_CHANNELS    (MAX_CHANNELS),
		.MAX_SAMPLE_BITS (MAX_SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_sum     (q_dout[ENT_W-1 -: SUM_W]),
		.q_bits    (q_dout[CH_W +: BW]),
		.q_chans   (q_dout[CH_W-1:0]),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_data  (res_data),
		.res_ready (res_ready)
	);

	// output register: refill in the same cycle the old result is popped
	assign res_ready   = !out_valid_q || pop;
	assign empty       = !out_valid_q;
	assign mono_sample = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_data_q <= res_data;
		end
	end

	// a finished frame only enters the queue on a byte that was taken
	`PM16_ASSERT_IMPL(a_push_on_accept, q_push, in_accept, "frame queued without byte transfer")
	// a handed-over result is on offer in the next cycle
	`PM16_ASSERT_NEXT(a_result_lands, res_valid && res_ready, !empty, "result lost in handover")
	// a pop with nothing arriving drains the output register
	`PM16_ASSERT_NEXT(a_pop_drains, pop && !empty && !res_valid, empty, "popped result repeated")

endmodule

/* src/pm16_front.sv */
module pm16_front #(
	parameter int MAX_CHANNELS    = pm16_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_SAMPLE_BITS = pm16_pkg::DEF_MAX_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pm16_pkg::cfg_t                       cfg,
	input  logic                                 clear,
	input  logic                                 in_valid,
	input  logic [pm16_pkg::BYTE_W-1:0]          in_byte,
	output logic                                 q_push,
	output logic signed [MAX_SAMPLE_BITS+$clog2(MAX_CHANNELS)-1:0] q_sum,
	output logic [$clog2(MAX_SAMPLE_BITS+1)-1:0] q_bits,
	output logic [$clog2(MAX_CHANNELS+1)-1:0]    q_chans
);

	localparam int SUM_W     = MAX_SAMPLE_BITS + $clog2(MAX_CHANNELS);
	localparam int BW        = $clog2(MAX_SAMPLE_BITS + 1);
	localparam int CH_W      = $clog2(MAX_CHANNELS + 1);
	localparam int ASM_BYTES = (MAX_SAMPLE_BITS + 7) / 8;
	localparam int ASM_W     = ASM_BYTES * 8;
	localparam int NB_W      = $clog2(ASM_BYTES + 1);
	localparam int POS_W     = $clog2((1 << pm16_pkg::PAD_W) + ASM_BYTES);

	logic [POS_W-1:0]        pos_q;
	logic [CH_W-1:0]         chan_q;
	logic [ASM_W-1:0]        asm_q;
	logic signed [SUM_W-1:0] sum_q;

	logic [BW-1:0]           eff_bits;
	logic [CH_W-1:0]         eff_chans;
	logic [NB_W-1:0]         nbytes;
	logic [POS_W-1:0]        k;
	logic [ASM_W-1:0]        asm_next;
	logic                    slot_end;
	logic                    chan_last;
	logic [2:0]              shamt;
	logic [ASM_W-1:0]        raw;
	logic [ASM_W-1:0]        flip;
	logic [ASM_W-1:0]        mask;
	logic [ASM_W-1:0]        v;
	logic                    sgn;
	logic [ASM_W-1:0]        smp;
	logic signed [SUM_W-1:0] sum_next;

	always_comb begin
		// clamp the register values to the supported range
		if (cfg.bits == '0) begin
			eff_bits = BW'(1);
		end else if (int'(cfg.bits) > MAX_SAMPLE_BITS) begin
			eff_bits = BW'(MAX_SAMPLE_BITS);
		end else begin
			eff_bits = BW'(cfg.bits);
		end
		if (cfg.chans == '0) begin
			eff_chans = CH_W'(1);
		end else if (int'(cfg.chans) > MAX_CHANNELS) begin
			eff_chans = CH_W'(MAX_CHANNELS);
		end else begin
			eff_chans = CH_W'(cfg.chans);
		end
		nbytes = NB_W'((32'(eff_bits) + 32'd7) >> 3);

		// gather sample bytes, least significant first
		k        = pos_q - POS_W'(cfg.pad);
		asm_next = asm_q;
		if (int'(pos_q) >= int'(cfg.pad) && int'(k) < ASM_BYTES) begin
			asm_next = asm_q | (ASM_W'(in_byte) << {k, 3'b000});
		end
		slot_end  = (int'(pos_q) + 1 >= int'(cfg.pad) + int'(nbytes));
		chan_last = (int'(chan_q) + 1 >= int'(eff_chans));

		// right-justify, offset narrow samples, sign-extend
		shamt = 3'((32'(nbytes) << 3) - 32'(eff_bits));
		raw   = asm_next >> shamt;
		flip  = (eff_bits <= BW'(8)) ? (ASM_W'(1) << (eff_bits - BW'(1))) : '0;
		mask  = ~({ASM_W{1'b1}} << eff_bits);
		v     = raw ^ flip;
		sgn   = |(v & (ASM_W'(1) << (eff_bits - BW'(1))));
		smp   = sgn ? (v | ~mask) : (v & mask);
		sum_next = sum_q + SUM_W'($signed(smp));
	end

	assign q_push  = in_valid && slot_end && chan_last;
	assign q_sum   = sum_next;
	assign q_bits  = eff_bits;
	assign q_chans = eff_chans;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			chan_q <= '0;
			asm_q  <= '0;
			sum_q  <= '0;
		end else if (clear) begin
			pos_q  <= '0;
			chan_q <= '0;
			asm_q  <= '0;
			sum_q  <= '0;
		end else if (in_valid) begin
			if (!slot_end) begin
				pos_q <= pos_q + POS_W'(1);
				asm_q <= asm_next;
			end else begin
				pos_q <= '0;
				asm_q <= '0;
				if (chan_last) begin
					chan_q <= '0;
					sum_q  <= '0;
				end else begin
					chan_q <= chan_q + CH_W'(1);
					sum_q  <= sum_next;
				end
			end
		end
	end

endmodule

/* src/pm16_fifo.sv */
module pm16_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = pm16_pkg::QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

/* src/pm16_back.sv */
module pm16_back #(
	parameter int MAX_CHANNELS    = pm16_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_SAMPLE_BITS = pm16_pkg::DEF_MAX_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	input  logic signed [MAX_SAMPLE_BITS+$clog2(MAX_CHANNELS)-1:0] q_sum,
	input  logic [$clog2(MAX_SAMPLE_BITS+1)-1:0] q_bits,
	input  logic [$clog2(MAX_CHANNELS+1)-1:0]    q_chans,
	output logic                                 q_pop,
	output logic                                 res_valid,
	output logic signed [pm16_pkg::OUT_W-1:0]    res_data,
	input  logic                                 res_ready
);

	localparam int SUM_W  = MAX_SAMPLE_BITS + $clog2(MAX_CHANNELS);
	localparam int CH_W   = $clog2(MAX_CHANNELS + 1);
	localparam int SCL_W  = pm16_pkg::OUT_W + $clog2(MAX_CHANNELS) + 1;
	localparam int WIDE_W = (SUM_W > SCL_W) ? SUM_W : SCL_W;
	localparam int CNT_W  = $clog2(SCL_W + 1);

	pm16_pkg::bk_state_t state_q, state_d;

	logic [CNT_W-1:0]  cnt_q;
	logic [SCL_W-1:0]  quo_q;
	logic [CH_W-1:0]   rem_q;
	logic [CH_W-1:0]   div_q;
	logic              neg_q;

	logic [pm16_pkg::SH_W-1:0] sh;
	logic signed [WIDE_W-1:0]  sum_w;
	logic signed [WIDE_W-1:0]  scaled_w;
	logic signed [SCL_W-1:0]   scaled;
	logic                      neg;
	logic [SCL_W-1:0]          mag;
	logic [CH_W:0]             trial;
	logic                      ge;
	logic [CH_W-1:0]           rem_nx;

	// scale the frame sum to 16-bit range and split off its sign
	always_comb begin
		if (int'(q_bits) < pm16_pkg::OUT_W) begin
			sh = pm16_pkg::SH_W'(pm16_pkg::OUT_W - int'(q_bits));
		end else begin
			sh = pm16_pkg::SH_W'(int'(q_bits) - pm16_pkg::OUT_W);
		end
		sum_w = WIDE_W'(q_sum);
		if (int'(q_bits) < pm16_pkg::OUT_W) begin
			scaled_w = sum_w <<< sh;
		end else begin
			scaled_w = sum_w >>> sh;
		end
		scaled = SCL_W'(scaled_w);
		neg    = scaled[SCL_W-1];
		mag    = neg ? SCL_W'(-scaled) : SCL_W'(scaled);
	end

	// one restoring-division step per cycle while in the divide state
	always_comb begin
		trial  = {rem_q, quo_q[SCL_W-1]};
		ge     = (trial >= {1'b0, div_q});
		rem_nx = ge ? CH_W'(trial - {1'b0, div_q}) : CH_W'(trial);
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			pm16_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop   = 1'b1;
					state_d = pm16_pkg::BK_DIV;
				end
			end
			pm16_pkg::BK_DIV: begin
				if (cnt_q == CNT_W'(SCL_W - 1)) begin
					state_d = pm16_pkg::BK_DONE;
				end
			end
			pm16_pkg::BK_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = pm16_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = pm16_pkg::BK_IDLE;
			end
		endcase
	end

	assign res_data = neg_q ? pm16_pkg::OUT_W'(-quo_q) : pm16_pkg::OUT_W'(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pm16_pkg::BK_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				cnt_q <= '0;
			end else if (state_q == pm16_pkg::BK_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			quo_q <= mag;
			rem_q <= '0;
			div_q <= q_chans;
			neg_q <= neg;
		end else if (state_q == pm16_pkg::BK_DIV) begin
			quo_q <= {quo_q[SCL_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

endmodule
